// ===== rtl/table_interp_1d_assert.svh =====
// Assertion macros for the table interpolator.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef TABLE_INTERP_1D_ASSERT_SVH
`define TABLE_INTERP_1D_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TI1D_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("table_interp_1d: assertion failed");
`define TI1D_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("table_interp_1d: assertion failed");
`else
`define TI1D_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TI1D_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/ti1d_pkg.sv =====
// Shared types and codes of the table interpolator.
// No dependencies; used by ti1d_ctrl, ti1d_dp and table_interp_1d.
package ti1d_pkg;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [2:0] ST_INTERP   = 3'd0;
    localparam logic [2:0] ST_EXTRAP   = 3'd1;
    localparam logic [2:0] ST_HELD     = 3'd2;
    localparam logic [2:0] ST_ACCEPTED = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;
    localparam logic [2:0] ST_WRITTEN  = 3'd5;

    localparam logic [2:0] CFG_INTERP = 3'd0;
    localparam logic [2:0] CFG_EXTRAP = 3'd1;
    localparam logic [2:0] CFG_COUNT  = 3'd2;
    localparam logic [2:0] CFG_LOWER  = 3'd3;
    localparam logic [2:0] CFG_UPPER  = 3'd4;

    localparam logic [1:0] IM_LINEAR  = 2'd0;
    localparam logic [1:0] IM_NEAREST = 2'd1;
    localparam logic [1:0] IM_NEXT    = 2'd2;

    localparam logic [1:0] EM_CLIP    = 2'd0;
    localparam logic [1:0] EM_LINEAR  = 2'd1;
    localparam logic [1:0] EM_SPECIFY = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         point_index;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic [2:0]         status;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic chk;
        logic srch;
        logic pair;
        logic prep;
        logic div;
        logic mul;
        logic fin;
    } dp_cmd_t;

    typedef struct packed {
        logic table_ok;
        logic chk_done;
        logic srch_done;
        logic pair_done;
        logic need_line;
        logic div_done;
        logic mul_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/ti1d_ctrl.sv =====
// Sequencer of the table interpolator: steps one item through check,
// search, pair fetch, divide and multiply. Depends on ti1d_pkg.
module ti1d_ctrl import ti1d_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_op,
    output logic       s_ready,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CHK  = 8'b0000_0010,
        S_SRCH = 8'b0000_0100,
        S_PAIR = 8'b0000_1000,
        S_PREP = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_op == OP_COMMIT) begin
                        state_next = S_CHK;
                    end else if (s_op == OP_LOOKUP && stat.table_ok) begin
                        state_next = S_SRCH;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CHK: begin
                cmd.chk = 1'b1;
                if (stat.chk_done) state_next = S_DONE;
            end
            S_SRCH: begin
                cmd.srch = 1'b1;
                if (stat.srch_done) state_next = S_PAIR;
            end
            S_PAIR: begin
                cmd.pair = 1'b1;
                if (stat.pair_done) state_next = stat.need_line ? S_PREP : S_DONE;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div = 1'b1;
                if (stat.div_done) state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                if (stat.mul_done) state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the beat
                if (stat.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ti1d_dp.sv =====
// Datapath of the table interpolator: breakpoint memories, table check,
// binary search, restoring divider, shift-add multiplier, output register.
// Depends on ti1d_pkg; driven by ti1d_ctrl.
module ti1d_dp import ti1d_pkg::*; #(
    parameter int POINTS    = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  in_item_t    s_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam int IDX_W = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CNT_W = $clog2(POINTS + 1);
    localparam int Q_W   = 33 + FRAC_BITS;
    localparam int A_W   = Q_W + 2;
    localparam int SC_W  = $clog2(Q_W + 1);
    localparam logic [Q_W-1:0] ONE  = Q_W'(1) << FRAC_BITS;
    localparam logic [Q_W-1:0] HALF = ONE >> 1;
    localparam logic [A_W-1:0] LIM  = A_W'(1) << Q_W;
    localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN = -36'sh0_8000_0000;

    // configuration
    logic [1:0]         interp_reg, extrap_reg;
    logic [8:0]         pcount_reg;
    logic signed [31:0] lower_reg, upper_reg;

    // table state
    logic               table_ok_reg;
    logic [CNT_W-1:0]   active_reg;
    logic signed [31:0] last_reg;

    logic signed [31:0] x_mem [POINTS];
    logic signed [31:0] y_mem [POINTS];
    logic signed [31:0] x_rd_reg, y_rd_reg;
    logic [IDX_W-1:0]   rd_addr;

    in_item_t           item_reg;
    logic               chk_ok_reg;
    logic [CNT_W-1:0]   nchk_reg, cnt_reg, lo_reg, hi_reg;
    logic               ph_reg;
    logic signed [31:0] prev_reg, xa_reg, ya_reg, xb_reg, yb_reg;

    logic [32:0]        den_reg, rem_reg, md_reg;
    logic [Q_W-1:0]     dvd_reg, q_reg;
    logic               zden_reg, pneg_reg, ovf_reg;
    logic [A_W-1:0]     acc_reg;
    logic [SC_W-1:0]    sc_reg;

    out_item_t          out_reg;
    logic               mval_reg;

    // search and pair addressing
    logic [CNT_W:0]     mid;
    logic [CNT_W-1:0]   base;
    logic               low, high, outside;

    assign mid     = ({1'b0, lo_reg} + {1'b0, hi_reg} + (CNT_W+1)'(1)) >> 1;
    assign low     = (lo_reg == '0);
    assign high    = (lo_reg >= active_reg);
    assign outside = low | high;

    always_comb begin
        priority if (low) begin
            base = '0;
        end else if (high) begin
            base = active_reg - CNT_W'(2);
        end else begin
            base = lo_reg - CNT_W'(1);
        end
    end

    always_comb begin
        priority if (cmd.chk) begin
            rd_addr = IDX_W'(cnt_reg);
        end else if (cmd.srch) begin
            rd_addr = IDX_W'(mid - (CNT_W+1)'(1));
        end else begin
            rd_addr = IDX_W'(base + ((cnt_reg != '0) ? CNT_W'(1) : CNT_W'(0)));
        end
    end

    // divider and multiplier steps
    logic [33:0]        trial;
    logic               ge;
    logic [Q_W-1:0]     mw;
    logic [A_W-1:0]     mac;

    assign trial = {rem_reg, dvd_reg[Q_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign mw    = zden_reg ? HALF : q_reg;
    assign mac   = {acc_reg[A_W-2:0], 1'b0} + (md_reg[32] ? {2'b00, mw} : '0);

    // operand preparation
    logic signed [32:0] num_w, den_w, dy_w;
    logic [32:0]        num_mag, dy_mag;
    logic               zden_w, wneg_w;

    always_comb begin
        num_w   = 33'(item_reg.x_value) - 33'(xa_reg);
        den_w   = 33'(xb_reg) - 33'(xa_reg);
        dy_w    = 33'(yb_reg) - 33'(ya_reg);
        num_mag = num_w[32] ? 33'(-num_w) : 33'(num_w);
        dy_mag  = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
        zden_w  = den_w[32] || (den_w == '0);
        wneg_w  = num_w[32] && !zden_w;
    end

    // line result
    logic [A_W-1:0]     rnd;
    logic signed [35:0] dsum;
    logic signed [31:0] line_res;

    always_comb begin
        rnd  = pneg_reg ? (acc_reg + A_W'(ONE - Q_W'(1))) : acc_reg;
        dsum = pneg_reg ? (36'(ya_reg) - 36'(rnd >> FRAC_BITS))
                        : (36'(ya_reg) + 36'(rnd >> FRAC_BITS));
        priority if (ovf_reg) begin
            line_res = pneg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (dsum > SAT_MAX) begin
            line_res = 32'sh7FFF_FFFF;
        end else if (dsum < SAT_MIN) begin
            line_res = 32'sh8000_0000;
        end else begin
            line_res = dsum[31:0];
        end
    end

    // final answer of the item
    logic signed [33:0] dl, dr;
    logic signed [31:0] res_w;
    logic [2:0]         status_w;
    logic               upd_last;

    always_comb begin
        dl       = 34'(item_reg.x_value) - 34'(xa_reg);
        dr       = 34'(xb_reg) - 34'(item_reg.x_value);
        res_w    = '0;
        status_w = ST_REJECTED;
        upd_last = 1'b0;
        unique case (item_reg.op)
            OP_WRITE: status_w = ST_WRITTEN;
            OP_COMMIT: status_w = chk_ok_reg ? ST_ACCEPTED : ST_REJECTED;
            OP_LOOKUP: begin
                if (!table_ok_reg) begin
                    res_w    = last_reg;
                    status_w = ST_HELD;
                end else if (outside) begin
                    status_w = ST_EXTRAP;
                    upd_last = 1'b1;
                    unique case (extrap_reg)
                        EM_CLIP:    res_w = low ? ya_reg : yb_reg;
                        EM_LINEAR:  res_w = line_res;
                        EM_SPECIFY: res_w = low ? lower_reg : upper_reg;
                        default: begin
                            res_w    = last_reg;
                            status_w = ST_HELD;
                            upd_last = 1'b0;
                        end
                    endcase
                end else begin
                    status_w = ST_INTERP;
                    upd_last = 1'b1;
                    unique case (interp_reg)
                        IM_LINEAR:  res_w = line_res;
                        IM_NEAREST: res_w = (dl <= dr) ? ya_reg : yb_reg;
                        IM_NEXT:    res_w = yb_reg;
                        default:    res_w = ya_reg;
                    endcase
                end
            end
            default: status_w = ST_REJECTED;
        endcase
    end

    always_comb begin
        stat.table_ok  = table_ok_reg;
        stat.chk_done  = !chk_ok_reg || (cnt_reg == nchk_reg);
        stat.srch_done = (lo_reg == hi_reg);
        stat.pair_done = (cnt_reg == CNT_W'(2));
        stat.need_line = outside ? (extrap_reg == EM_LINEAR) : (interp_reg == IM_LINEAR);
        stat.div_done  = (sc_reg == SC_W'(Q_W - 1));
        stat.mul_done  = (sc_reg == SC_W'(32));
        stat.out_free  = !mval_reg || m_ready;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.fin && item_reg.op == OP_WRITE && 32'(item_reg.point_index) < POINTS) begin
            x_mem[IDX_W'(item_reg.point_index)] <= item_reg.x_value;
            y_mem[IDX_W'(item_reg.point_index)] <= item_reg.y_value;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interp_reg <= '0;
            extrap_reg <= '0;
            pcount_reg <= '0;
            lower_reg  <= '0;
            upper_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INTERP: interp_reg <= cfg_wdata[1:0];
                CFG_EXTRAP: extrap_reg <= cfg_wdata[1:0];
                CFG_COUNT:  pcount_reg <= cfg_wdata[8:0];
                CFG_LOWER:  lower_reg  <= cfg_wdata;
                CFG_UPPER:  upper_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // table state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_ok_reg <= 1'b0;
            active_reg   <= '0;
            last_reg     <= '0;
            mval_reg     <= 1'b0;
        end else begin
            if (cmd.fin) begin
                mval_reg       <= 1'b1;
                out_reg.result <= res_w;
                out_reg.status <= status_w;
                if (item_reg.op == OP_WRITE) begin
                    table_ok_reg <= 1'b0;
                end else if (item_reg.op == OP_COMMIT) begin
                    table_ok_reg <= chk_ok_reg;
                    active_reg   <= chk_ok_reg ? nchk_reg : '0;
                end
                if (upd_last) last_reg <= res_w;
            end else if (m_ready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg   <= s_data;
            cnt_reg    <= '0;
            ph_reg     <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= active_reg;
            nchk_reg   <= CNT_W'(pcount_reg);
            chk_ok_reg <= (pcount_reg >= 9'd2) && (32'(pcount_reg) <= POINTS);
        end
        if (cmd.chk && !stat.chk_done) begin
            ph_reg <= !ph_reg;
            if (ph_reg) begin
                if (cnt_reg != '0 && x_rd_reg <= prev_reg) chk_ok_reg <= 1'b0;
                prev_reg <= x_rd_reg;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.srch && !stat.srch_done) begin
            ph_reg <= !ph_reg;
            if (ph_reg) begin
                if (x_rd_reg <= item_reg.x_value) begin
                    lo_reg <= CNT_W'(mid);
                end else begin
                    hi_reg <= CNT_W'(mid - (CNT_W+1)'(1));
                end
            end
        end
        if (cmd.pair) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                xa_reg <= x_rd_reg;
                ya_reg <= y_rd_reg;
            end
            if (cnt_reg == CNT_W'(2)) begin
                xb_reg <= x_rd_reg;
                yb_reg <= y_rd_reg;
            end
        end
        if (cmd.prep) begin
            dvd_reg  <= Q_W'(num_mag) << FRAC_BITS;
            den_reg  <= 33'(den_w);
            zden_reg <= zden_w;
            md_reg   <= dy_mag;
            pneg_reg <= wneg_w ^ dy_w[32];
            rem_reg  <= '0;
            q_reg    <= '0;
            sc_reg   <= '0;
        end
        if (cmd.div) begin
            rem_reg <= ge ? 33'(trial - {1'b0, den_reg}) : trial[32:0];
            q_reg   <= {q_reg[Q_W-2:0], ge};
            dvd_reg <= dvd_reg << 1;
            sc_reg  <= stat.div_done ? '0 : sc_reg + SC_W'(1);
            if (stat.div_done) begin
                acc_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
        if (cmd.mul) begin
            // product saturates once it cannot fit the result
            acc_reg <= mac;
            md_reg  <= md_reg << 1;
            sc_reg  <= sc_reg + SC_W'(1);
            if (mac >= LIM) ovf_reg <= 1'b1;
        end
    end

    assign m_valid = mval_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/table_interp_1d.sv =====
// Top level of the one-dimensional breakpoint table interpolator.
// Depends on ti1d_pkg, ti1d_ctrl, ti1d_dp and table_interp_1d_assert.svh.
//
// Usage: beats on s_* carry op, point_index, x_value, y_value (Q16.16).
// Each beat gives exactly one beat on m_* with result and status.
// Write beats store one breakpoint and clear the table valid flag; a
// commit beat checks the first point_count x values for strict increase;
// lookup beats interpolate or extrapolate per interp_mode / extrap_mode.
// Registers are written through cfg_we / cfg_index / cfg_wdata; users write
// them only while idle; the block itself does not enforce this. Write, unused
// op and lookup on an invalid table go straight to the result; a commit makes
// one memory read and one compare per entry; a lookup runs the binary search
// (a read and a compare per step) and the pair fetch, and for linear results
// the bit-serial divider and multiplier, whose quotient carries FRAC_BITS
// fraction bits (16 at Q16.16).
// One item is in work at a time; the next beat is taken as soon as the
// result sits in the output register, even if m_ready is low.
// Reset clears the table valid flag, the configuration and the held last
// result; breakpoint memories are not cleared. A stalled receiver holds
// the result beat and, once a second result is ready, the sequencer.
`include "table_interp_1d_assert.svh"
module table_interp_1d import ti1d_pkg::*; #(
    parameter int POINTS    = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     non_lookup_beat;

    ti1d_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ti1d_dp #(
        .POINTS    (POINTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign non_lookup_beat = m_valid && (m_data.status == ST_WRITTEN ||
                                         m_data.status == ST_ACCEPTED ||
                                         m_data.status == ST_REJECTED);

    `TI1D_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `TI1D_ASSERT_IMP(a_result_at_idle, aclk, aresetn, $rose(m_valid), s_ready)
    `TI1D_ASSERT_IMP(a_zero_for_non_lookup, aclk, aresetn, non_lookup_beat, m_data.result == 32'sd0)

endmodule
